>>> design/rth_pkg.sv
package rth_pkg;

    // coordinate format and working width of the datapath
    localparam int CW        = 32;
    localparam int W         = 4 * CW + 16;
    localparam int AW        = 6;
    localparam int MEM_DEPTH = 2 ** AW;
    localparam int NCFG      = 6;
    localparam int NVERT     = 9;

    // serial step counts: direction, coordinate difference, cross product
    localparam logic [7:0] MC_D     = 8'(CW);
    localparam logic [7:0] MC_E     = 8'(CW + 1);
    localparam logic [7:0] MC_Y     = 8'(2 * CW + 3);
    localparam logic [7:0] DIV_LAST = 8'(W - 1);
    localparam logic [3:0] LOAD_LAST = 4'(NCFG + NVERT - 1);

    typedef logic [AW-1:0] t_addr;

    typedef enum logic [2:0] {
        OP_END, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_SAT, OP_CHK, OP_ZCHK
    } t_op;

    typedef enum logic [2:0] {
        S_IDLE, S_LOAD, S_READ, S_EXEC, S_ITER, S_WRITE, S_DONE
    } t_state;

    typedef struct packed {
        t_op        op;
        logic       vec;
        t_addr      dst;
        logic       dv;
        t_addr      a;
        logic       av;
        logic [1:0] ar;
        t_addr      b;
        logic       bv;
        logic [1:0] br;
        logic [7:0] cnt;
    } t_instr;

    typedef struct packed {
        logic [NVERT-1:0][CW-1:0] c;
    } t_tri;

    typedef logic [NCFG-1:0][CW-1:0] t_cfg;

    // head of the triangle queue as seen by the engine
    typedef struct packed {
        logic valid;
        t_tri vtx;
    } t_qhead;

    // scratch register map
    localparam t_addr R_O   = 6'd0;
    localparam t_addr R_D   = 6'd3;
    localparam t_addr R_V0  = 6'd6;
    localparam t_addr R_V1  = 6'd9;
    localparam t_addr R_V2  = 6'd12;
    localparam t_addr R_E1  = 6'd15;
    localparam t_addr R_E2  = 6'd18;
    localparam t_addr R_N   = 6'd21;
    localparam t_addr R_TA  = 6'd24;
    localparam t_addr R_TB  = 6'd27;
    localparam t_addr R_DEN = 6'd30;
    localparam t_addr R_NUM = 6'd31;
    localparam t_addr R_P   = 6'd32;
    localparam t_addr R_X   = 6'd35;
    localparam t_addr R_U   = 6'd38;
    localparam t_addr R_V   = 6'd41;
    localparam t_addr R_Y   = 6'd44;
    localparam t_addr R_Z   = 6'd47;

    function automatic t_instr mk(t_op op, logic vec, t_addr dst, logic dv,
                                  t_addr a, logic av, logic [1:0] ar,
                                  t_addr b, logic bv, logic [1:0] br,
                                  logic [7:0] cnt);
        t_instr r;
        r.op  = op;
        r.vec = vec;
        r.dst = dst;
        r.dv  = dv;
        r.a   = a;
        r.av  = av;
        r.ar  = ar;
        r.b   = b;
        r.bv  = bv;
        r.br  = br;
        r.cnt = cnt;
        return r;
    endfunction

    function automatic t_instr v3(t_op op, t_addr dst, t_addr a, logic [1:0] ar,
                                  t_addr b, logic [1:0] br, logic [7:0] cnt);
        return mk(op, 1'b1, dst, 1'b1, a, 1'b1, ar, b, 1'b1, br, cnt);
    endfunction

    function automatic t_instr sc(t_op op, t_addr dst, t_addr a, t_addr b);
        return mk(op, 1'b0, dst, 1'b0, a, 1'b0, 2'd0, b, 1'b0, 2'd0, 8'd0);
    endfunction

    // same-side test of the point against edge va->vb, opposite vertex vc
    function automatic t_instr side_ins(logic [3:0] s, t_addr va, t_addr vb, t_addr vc);
        t_instr r;
        case (s)
            4'd0:    r = v3(OP_SUB, R_X, vb, 2'd0, va, 2'd0, 8'd0);
            4'd1:    r = v3(OP_SUB, R_U, R_P, 2'd0, va, 2'd0, 8'd0);
            4'd2:    r = v3(OP_SUB, R_V, vc, 2'd0, va, 2'd0, 8'd0);
            4'd3:    r = v3(OP_MUL, R_TA, R_X, 2'd1, R_U, 2'd2, MC_E);
            4'd4:    r = v3(OP_MUL, R_TB, R_X, 2'd2, R_U, 2'd1, MC_E);
            4'd5:    r = v3(OP_SUB, R_Y, R_TA, 2'd0, R_TB, 2'd0, 8'd0);
            4'd6:    r = v3(OP_MUL, R_TA, R_X, 2'd1, R_V, 2'd2, MC_E);
            4'd7:    r = v3(OP_MUL, R_TB, R_X, 2'd2, R_V, 2'd1, MC_E);
            4'd8:    r = v3(OP_SUB, R_Z, R_TA, 2'd0, R_TB, 2'd0, 8'd0);
            4'd9:    r = v3(OP_MUL, R_TA, R_Y, 2'd0, R_Z, 2'd0, MC_Y);
            4'd10:   r = sc(OP_ADD, R_NUM, R_TA, R_TA + 6'd1);
            4'd11:   r = sc(OP_ADD, R_NUM, R_NUM, R_TA + 6'd2);
            4'd12:   r = sc(OP_CHK, R_NUM, R_NUM, R_NUM);
            default: r = sc(OP_END, R_NUM, R_NUM, R_NUM);
        endcase
        return r;
    endfunction

    // microcode: normal, plane crossing, then a same-side test for each edge
    function automatic t_instr rth_rom(t_addr pc);
        t_instr r;
        if (pc >= 6'd17 && pc < 6'd30) begin
            r = side_ins(4'(pc - 6'd17), R_V1, R_V2, R_V0);
        end else if (pc >= 6'd30 && pc < 6'd43) begin
            r = side_ins(4'(pc - 6'd30), R_V2, R_V0, R_V1);
        end else if (pc >= 6'd43 && pc < 6'd56) begin
            r = side_ins(4'(pc - 6'd43), R_V0, R_V1, R_V2);
        end else begin
            case (pc)
                6'd0:    r = v3(OP_SUB, R_E1, R_V1, 2'd0, R_V0, 2'd0, 8'd0);
                6'd1:    r = v3(OP_SUB, R_E2, R_V2, 2'd0, R_V0, 2'd0, 8'd0);
                6'd2:    r = v3(OP_MUL, R_TA, R_E1, 2'd1, R_E2, 2'd2, MC_E);
                6'd3:    r = v3(OP_MUL, R_TB, R_E1, 2'd2, R_E2, 2'd1, MC_E);
                6'd4:    r = v3(OP_SUB, R_N, R_TA, 2'd0, R_TB, 2'd0, 8'd0);
                6'd5:    r = v3(OP_MUL, R_TA, R_N, 2'd0, R_D, 2'd0, MC_D);
                6'd6:    r = sc(OP_ADD, R_DEN, R_TA, R_TA + 6'd1);
                6'd7:    r = sc(OP_ADD, R_DEN, R_DEN, R_TA + 6'd2);
                6'd8:    r = sc(OP_ZCHK, R_DEN, R_DEN, R_DEN);
                6'd9:    r = v3(OP_SUB, R_U, R_V0, 2'd0, R_O, 2'd0, 8'd0);
                6'd10:   r = v3(OP_MUL, R_TA, R_N, 2'd0, R_U, 2'd0, MC_E);
                6'd11:   r = sc(OP_ADD, R_NUM, R_TA, R_TA + 6'd1);
                6'd12:   r = sc(OP_ADD, R_NUM, R_NUM, R_TA + 6'd2);
                6'd13:   r = mk(OP_MUL, 1'b1, R_TA, 1'b1, R_NUM, 1'b0, 2'd0,
                                R_D, 1'b1, 2'd0, MC_D);
                6'd14:   r = mk(OP_DIV, 1'b1, R_TA, 1'b1, R_TA, 1'b1, 2'd0,
                                R_DEN, 1'b0, 2'd0, 8'd0);
                6'd15:   r = v3(OP_ADD, R_TA, R_O, 2'd0, R_TA, 2'd0, 8'd0);
                6'd16:   r = v3(OP_SAT, R_P, R_TA, 2'd0, R_TA, 2'd0, 8'd0);
                default: r = sc(OP_END, R_NUM, R_NUM, R_NUM);
            endcase
        end
        return r;
    endfunction

endpackage

>>> design/rth_queue.sv
module rth_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  rth_pkg::t_tri  i_tri,
    output logic           o_stall,
    output rth_pkg::t_qhead o_head,
    input  logic           i_pop
);

    rth_pkg::t_tri r_mem [2];
    logic          r_wp;
    logic          r_rp;
    logic [1:0]    r_count;
    logic          push;

    assign o_stall     = (r_count == 2'd2);
    assign push        = i_valid && !o_stall;
    assign o_head.valid = (r_count != 2'd0);
    assign o_head.vtx   = r_mem[r_rp];

    // store incoming beats
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_tri;
        end
    end

    // advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            r_count <= r_count + {1'b0, push} - {1'b0, i_pop};
        end
    end

endmodule

>>> design/rth_engine.sv
module rth_engine (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  rth_pkg::t_cfg                     i_cfg,
    input  rth_pkg::t_qhead                   i_head,
    output logic                              o_pop,
    input  logic                              i_out_stall,
    output logic                              o_out_valid,
    output logic                              o_hit,
    output logic [2:0][rth_pkg::CW-1:0]       o_point
);

    localparam logic signed [rth_pkg::W-1:0] SAT_MAX =
        {{(rth_pkg::W - rth_pkg::CW + 1){1'b0}}, {(rth_pkg::CW - 1){1'b1}}};
    localparam logic signed [rth_pkg::W-1:0] SAT_MIN =
        {{(rth_pkg::W - rth_pkg::CW + 1){1'b1}}, {(rth_pkg::CW - 1){1'b0}}};

    function automatic rth_pkg::t_addr lane_addr(rth_pkg::t_addr base, logic v,
                                                 logic [1:0] rot, logic [1:0] lane);
        logic [2:0] s;
        logic [1:0] m;
        s = {1'b0, lane} + {1'b0, rot};
        case (s)
            3'd0:    m = 2'd0;
            3'd1:    m = 2'd1;
            3'd2:    m = 2'd2;
            3'd3:    m = 2'd0;
            3'd4:    m = 2'd1;
            default: m = 2'd0;
        endcase
        return v ? base + {4'd0, m} : base;
    endfunction

    logic [rth_pkg::W-1:0]           r_mem [rth_pkg::MEM_DEPTH];
    logic [rth_pkg::W-1:0]           r_rd_a;
    logic [rth_pkg::W-1:0]           r_rd_b;

    rth_pkg::t_state                 r_state, n_state;
    rth_pkg::t_addr                  r_pc, n_pc;
    logic [1:0]                      r_lane, n_lane;
    logic [3:0]                      r_cnt, n_cnt;
    logic [7:0]                      r_it, n_it;
    logic [rth_pkg::W-1:0]           r_acc, n_acc;
    logic [rth_pkg::W-1:0]           r_ma, n_ma;
    logic [rth_pkg::W-1:0]           r_mb, n_mb;
    logic                            r_neg, n_neg;
    logic                            r_hit, n_hit;
    logic                            r_zero, n_zero;
    logic [2:0][rth_pkg::CW-1:0]     r_p;
    logic                            r_out_valid, n_out_valid;
    logic                            r_out_hit, n_out_hit;
    logic [2:0][rth_pkg::CW-1:0]     r_out_p, n_out_p;

    rth_pkg::t_instr                 ins;
    rth_pkg::t_addr                  addr_a, addr_b, addr_d;
    logic                            wr_en;
    rth_pkg::t_addr                  wr_addr;
    logic [rth_pkg::W-1:0]           wr_data;
    logic                            p_wr;
    logic                            adv;
    logic                            last_lane;
    logic [rth_pkg::CW-1:0]          load_src;
    logic [rth_pkg::W-1:0]           sat_val;
    logic [rth_pkg::W-1:0]           trial;
    logic                            ge;
    logic                            hit_f;

    assign ins       = rth_pkg::rth_rom(r_pc);
    assign addr_a    = lane_addr(ins.a, ins.av, ins.ar, r_lane);
    assign addr_b    = lane_addr(ins.b, ins.bv, ins.br, r_lane);
    assign addr_d    = lane_addr(ins.dst, ins.dv, 2'd0, r_lane);
    assign last_lane = !ins.vec || (r_lane == 2'd2);
    assign hit_f     = r_hit && !r_zero;

    // pick the load source: ray registers first, then the nine vertex coordinates
    always_comb begin
        if (r_cnt < 4'(rth_pkg::NCFG)) begin
            load_src = i_cfg[r_cnt[2:0]];
        end else begin
            load_src = i_head.vtx.c[4'(r_cnt - 4'(rth_pkg::NCFG))];
        end
    end

    // clamp to the coordinate range
    always_comb begin
        if ($signed(r_rd_a) > SAT_MAX) begin
            sat_val = SAT_MAX;
        end else if ($signed(r_rd_a) < SAT_MIN) begin
            sat_val = SAT_MIN;
        end else begin
            sat_val = r_rd_a;
        end
    end

    // restoring divide step
    assign trial = {r_acc[rth_pkg::W-2:0], r_ma[rth_pkg::W-1]};
    assign ge    = (trial >= r_mb);

    // sequencer next state
    always_comb begin
        n_state     = r_state;
        n_pc        = r_pc;
        n_lane      = r_lane;
        n_cnt       = r_cnt;
        n_it        = r_it;
        n_acc       = r_acc;
        n_ma        = r_ma;
        n_mb        = r_mb;
        n_neg       = r_neg;
        n_hit       = r_hit;
        n_zero      = r_zero;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_hit   = r_out_hit;
        n_out_p     = r_out_p;
        wr_en       = 1'b0;
        wr_addr     = addr_d;
        wr_data     = r_acc;
        p_wr        = 1'b0;
        adv         = 1'b0;
        o_pop       = 1'b0;
        case (r_state)
            rth_pkg::S_IDLE: begin
                if (i_head.valid) begin
                    n_state = rth_pkg::S_LOAD;
                    n_cnt   = 4'd0;
                    n_hit   = 1'b1;
                    n_zero  = 1'b0;
                end
            end
            rth_pkg::S_LOAD: begin
                wr_en   = 1'b1;
                wr_addr = {2'b00, r_cnt};
                wr_data = {{(rth_pkg::W - rth_pkg::CW){load_src[rth_pkg::CW-1]}}, load_src};
                n_cnt   = r_cnt + 4'd1;
                if (r_cnt == rth_pkg::LOAD_LAST) begin
                    o_pop   = 1'b1;
                    n_pc    = '0;
                    n_lane  = 2'd0;
                    n_state = rth_pkg::S_READ;
                end
            end
            rth_pkg::S_READ: begin
                if (ins.op == rth_pkg::OP_END) begin
                    n_state = rth_pkg::S_DONE;
                end else begin
                    n_state = rth_pkg::S_EXEC;
                end
            end
            rth_pkg::S_EXEC: begin
                case (ins.op)
                    rth_pkg::OP_ADD: begin
                        wr_en   = 1'b1;
                        wr_data = r_rd_a + r_rd_b;
                        adv     = 1'b1;
                    end
                    rth_pkg::OP_SUB: begin
                        wr_en   = 1'b1;
                        wr_data = r_rd_a - r_rd_b;
                        adv     = 1'b1;
                    end
                    rth_pkg::OP_SAT: begin
                        wr_en   = 1'b1;
                        wr_data = sat_val;
                        p_wr    = 1'b1;
                        adv     = 1'b1;
                    end
                    rth_pkg::OP_CHK: begin
                        if (r_rd_a[rth_pkg::W-1]) begin
                            n_hit = 1'b0;
                        end
                        adv = 1'b1;
                    end
                    rth_pkg::OP_ZCHK: begin
                        if (r_rd_a == '0) begin
                            n_zero  = 1'b1;
                            n_state = rth_pkg::S_DONE;
                        end else begin
                            adv = 1'b1;
                        end
                    end
                    rth_pkg::OP_MUL: begin
                        n_acc   = '0;
                        n_ma    = r_rd_a;
                        n_mb    = r_rd_b;
                        n_it    = 8'd0;
                        n_state = rth_pkg::S_ITER;
                    end
                    rth_pkg::OP_DIV: begin
                        n_neg   = r_rd_a[rth_pkg::W-1] ^ r_rd_b[rth_pkg::W-1];
                        n_ma    = r_rd_a[rth_pkg::W-1] ? -r_rd_a : r_rd_a;
                        n_mb    = r_rd_b[rth_pkg::W-1] ? -r_rd_b : r_rd_b;
                        n_acc   = '0;
                        n_it    = 8'd0;
                        n_state = rth_pkg::S_ITER;
                    end
                    default: begin
                        n_state = rth_pkg::S_DONE;
                    end
                endcase
            end
            rth_pkg::S_ITER: begin
                n_it = r_it + 8'd1;
                if (ins.op == rth_pkg::OP_MUL) begin
                    // shift-add over the multiplier bits, sign bit weighs negative
                    if (r_mb[0]) begin
                        if (r_it == ins.cnt - 8'd1) begin
                            n_acc = r_acc - r_ma;
                        end else begin
                            n_acc = r_acc + r_ma;
                        end
                    end
                    n_ma = {r_ma[rth_pkg::W-2:0], 1'b0};
                    n_mb = {r_mb[rth_pkg::W-1], r_mb[rth_pkg::W-1:1]};
                    if (r_it == ins.cnt - 8'd1) begin
                        n_state = rth_pkg::S_WRITE;
                    end
                end else begin
                    // quotient bits shift into the dividend register
                    n_acc = ge ? trial - r_mb : trial;
                    n_ma  = {r_ma[rth_pkg::W-2:0], ge};
                    if (r_it == rth_pkg::DIV_LAST) begin
                        n_state = rth_pkg::S_WRITE;
                    end
                end
            end
            rth_pkg::S_WRITE: begin
                wr_en = 1'b1;
                if (ins.op == rth_pkg::OP_MUL) begin
                    wr_data = r_acc;
                end else begin
                    wr_data = r_neg ? -r_ma : r_ma;
                end
                adv = 1'b1;
            end
            rth_pkg::S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_out_hit   = hit_f;
                    n_out_p     = hit_f ? r_p : '0;
                    n_state     = rth_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = rth_pkg::S_IDLE;
            end
        endcase

        // advance to the next lane or instruction
        if (adv) begin
            if (last_lane) begin
                n_lane = 2'd0;
                n_pc   = r_pc + 6'd1;
            end else begin
                n_lane = r_lane + 2'd1;
            end
            n_state = rth_pkg::S_READ;
        end
    end

    // scratch memory, two registered read ports
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd_a <= r_mem[addr_a];
        r_rd_b <= r_mem[addr_b];
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_pc      <= n_pc;
        r_lane    <= n_lane;
        r_cnt     <= n_cnt;
        r_it      <= n_it;
        r_acc     <= n_acc;
        r_ma      <= n_ma;
        r_mb      <= n_mb;
        r_neg     <= n_neg;
        r_hit     <= n_hit;
        r_zero    <= n_zero;
        r_out_hit <= n_out_hit;
        r_out_p   <= n_out_p;
        if (p_wr) begin
            r_p[r_lane] <= sat_val[rth_pkg::CW-1:0];
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rth_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_hit       = r_out_hit;
    assign o_point     = r_out_p;

endmodule

>>> design/ray_triangle_hit_test_top.sv
// Ray / triangle hit test. Write the ray origin (indices 0..2) and direction
// (indices 3..5) as signed Q16.16 while the block is idle, then stream
// triangles in; each triangle gives one beat with the hit flag and the
// saturated intersection point (zero when there is no hit). When the
// denominator is zero the edge tests are skipped. One microcoded engine
// runs every product through a shared bit-serial multiplier and every
// quotient through a one-bit-per-cycle divider, so the multiply and divide
// steps take most of the time spent on a triangle.
// A two-entry input queue takes new triangles while the engine works and an
// output register holds a finished result until it is taken.
module ray_triangle_hit_test_top (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_wr_en,
    input  logic [2:0]              i_cfg_index,
    input  logic [rth_pkg::CW-1:0]  i_cfg_data,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic [rth_pkg::CW-1:0]  i_v0_x,
    input  logic [rth_pkg::CW-1:0]  i_v0_y,
    input  logic [rth_pkg::CW-1:0]  i_v0_z,
    input  logic [rth_pkg::CW-1:0]  i_v1_x,
    input  logic [rth_pkg::CW-1:0]  i_v1_y,
    input  logic [rth_pkg::CW-1:0]  i_v1_z,
    input  logic [rth_pkg::CW-1:0]  i_v2_x,
    input  logic [rth_pkg::CW-1:0]  i_v2_y,
    input  logic [rth_pkg::CW-1:0]  i_v2_z,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic                    o_hit,
    output logic [rth_pkg::CW-1:0]  o_point_x,
    output logic [rth_pkg::CW-1:0]  o_point_y,
    output logic [rth_pkg::CW-1:0]  o_point_z
);

    rth_pkg::t_cfg               r_cfg;
    rth_pkg::t_tri               in_tri;
    rth_pkg::t_qhead             head;
    logic                        pop;
    logic [2:0][rth_pkg::CW-1:0] point;

    // hold ray registers, drop writes past the list
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_wr_en && (i_cfg_index < 3'(rth_pkg::NCFG))) begin
            r_cfg[i_cfg_index] <= i_cfg_data;
        end
    end

    // pack the vertex beat
    assign in_tri.c[0] = i_v0_x;
    assign in_tri.c[1] = i_v0_y;
    assign in_tri.c[2] = i_v0_z;
    assign in_tri.c[3] = i_v1_x;
    assign in_tri.c[4] = i_v1_y;
    assign in_tri.c[5] = i_v1_z;
    assign in_tri.c[6] = i_v2_x;
    assign in_tri.c[7] = i_v2_y;
    assign in_tri.c[8] = i_v2_z;

    rth_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .i_tri   (in_tri),
        .o_stall (o_in_stall),
        .o_head  (head),
        .i_pop   (pop)
    );

    rth_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_head      (head),
        .o_pop       (pop),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_hit       (o_hit),
        .o_point     (point)
    );

    assign o_point_x = point[0];
    assign o_point_y = point[1];
    assign o_point_z = point[2];

endmodule

>>> design/rth_checker.sv
module rth_checker (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   o_out_valid,
    input logic                   i_out_stall,
    input logic                   o_hit,
    input logic [rth_pkg::CW-1:0] o_point_x,
    input logic [rth_pkg::CW-1:0] o_point_y,
    input logic [rth_pkg::CW-1:0] o_point_z
);

    // reset empties the output register
    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // a stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_hit)
            && $stable(o_point_x) && $stable(o_point_y) && $stable(o_point_z))
        else $error("stalled result changed");

    // a miss reports an all-zero point
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_hit |-> o_point_x == '0 && o_point_y == '0
            && o_point_z == '0)
        else $error("miss with nonzero point");

endmodule

bind ray_triangle_hit_test_top rth_checker u_rth_checker (.*);
